// ===== sv/mts_pkg.sv =====
// Shared sizes, command codes and status codes for the minimum-tracking stack.
package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = 11;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// ===== sv/mts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/min_tracking_stack.sv =====
// Minimum-tracking LIFO stack: top level with control, cached tops and two stores.
// Results: a push or a refused item gives its result in the cycle after the transfer;
// a pop that succeeds passes through the fetch state, waiting for the store read.
// Throughput: one item per cycle for pushes and refused items when each result is
// taken at once; a pop holds off new items until the read of the new top entries
// is done.
// Reset (rst, synchronous): counts cleared, stack empty, input stalled while rst is
// high; store contents are not cleared.
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      cmd,
  input  logic signed [DATA_W-1:0]  push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  top_value,
  output logic signed [DATA_W-1:0]  min_value,
  output logic [DEPTH_W-1:0]        depth,
  output logic                      is_empty,
  output logic [1:0]                status
);

  typedef enum logic [0:0] {S_IDLE, S_FETCH} state_t;

  state_t                    state;
  logic [COUNT_W-1:0]        value_count;
  logic [COUNT_W-1:0]        minimum_count;
  // Cached top entries of both stores; valid only while their count is non-zero
  logic signed [DATA_W-1:0]  value_top;
  logic signed [DATA_W-1:0]  min_top;
  logic                      drop_min;

  logic                      accept;
  logic                      full;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      min_take;
  logic                      min_match;
  logic                      out_load;
  logic [COUNT_W-1:0]        value_count_next;
  logic [COUNT_W-1:0]        minimum_count_next;
  logic [ADDR_W-1:0]         value_rd_idx;
  logic [ADDR_W-1:0]         min_rd_idx;
  logic [DATA_W-1:0]         value_rd_data;
  logic [DATA_W-1:0]         min_rd_data;
  logic signed [DATA_W-1:0]  fetched_min;

  // Hold off new work in reset, while a pop waits on the stores or a result is stuck
  assign in_stall = rst || (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign full      = (value_count == COUNT_W'(STACK_DEPTH));
  assign push_ok   = accept && (cmd == CMD_PUSH) && !full;
  assign pop_ok    = accept && (cmd == CMD_POP) && (value_count != '0);
  // New value joins the minimum store when that store is empty or it is not above its top
  assign min_take  = (minimum_count == '0) || (push_value <= min_top);
  assign min_match = (minimum_count != '0) && (min_top == value_top);

  // A result is loaded after a fetch, or straight away for anything but a good pop
  assign out_load = (state == S_FETCH) || (accept && !pop_ok);

  assign value_count_next   = value_count - COUNT_W'(1);
  assign minimum_count_next = minimum_count - COUNT_W'(1);

  // Address the entries just below the current tops, ready for a pop
  assign value_rd_idx = value_count[ADDR_W-1:0] - ADDR_W'(2);
  assign min_rd_idx   = minimum_count[ADDR_W-1:0] - ADDR_W'(2);

  assign fetched_min = drop_min ? $signed(min_rd_data) : min_top;

  mts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (value_count[ADDR_W-1:0]),
    .wr_data (push_value),
    .rd_addr (value_rd_idx),
    .rd_data (value_rd_data)
  );

  mts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_min_ram (
    .clk     (clk),
    .wr_en   (push_ok && min_take),
    .wr_addr (minimum_count[ADDR_W-1:0]),
    .wr_data (push_value),
    .rd_addr (min_rd_idx),
    .rd_data (min_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      value_count   <= '0;
      minimum_count <= '0;
      out_valid     <= 1'b0;
      drop_min      <= 1'b0;
    end else begin
      // Load a fresh result, or drop the held one once its transfer happens
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_PUSH) begin
              if (full) begin
                top_value <= value_top;
                min_value <= min_top;
                depth     <= DEPTH_W'(value_count);
                is_empty  <= 1'b0;
                status    <= ST_FULL;
              end else begin
                value_count <= value_count + COUNT_W'(1);
                value_top   <= push_value;
                if (min_take) begin
                  minimum_count <= minimum_count + COUNT_W'(1);
                  min_top       <= push_value;
                end
                top_value <= push_value;
                min_value <= min_take ? push_value : min_top;
                depth     <= DEPTH_W'(value_count + COUNT_W'(1));
                is_empty  <= 1'b0;
                status    <= ST_OK;
              end
            end else if (pop_ok) begin
              // Advance the counts now; the new tops arrive from the stores next cycle
              value_count <= value_count_next;
              drop_min    <= min_match;
              if (min_match) begin
                minimum_count <= minimum_count_next;
              end
              state <= S_FETCH;
            end else begin
              top_value <= '0;
              min_value <= '0;
              depth     <= '0;
              is_empty  <= 1'b1;
              status    <= ST_EMPTY;
            end
          end
        end
        S_FETCH: begin
          if (value_count != '0) begin
            value_top <= $signed(value_rd_data);
          end
          if (drop_min && (minimum_count != '0)) begin
            min_top <= $signed(min_rd_data);
          end
          top_value <= (value_count != '0) ? $signed(value_rd_data) : '0;
          min_value <= ((value_count != '0) && (minimum_count != '0)) ? fetched_min : '0;
          depth     <= DEPTH_W'(value_count);
          is_empty  <= (value_count == '0);
          status    <= ST_OK;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_min_not_above_values: assert property (@(posedge clk) disable iff (rst)
    minimum_count <= value_count)
    else $error("minimum store holds more entries than value store");

  a_fetch_output_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> !out_valid)
    else $error("pop result would overwrite a pending result");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> (value_count == $past(value_count) + COUNT_W'(1)))
    else $error("push did not advance the depth");

  a_empty_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> ((top_value == '0) && (min_value == '0) && (depth == '0)))
    else $error("empty result carries non-zero fields");

  a_pop_takes_fetch: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> (state == S_FETCH) && !out_valid)
    else $error("pop did not wait for the store read");
`endif

endmodule

// ===== tb/min_tracking_stack_checker.sv =====
// Checker for the minimum-tracking stack: predicts each result and compares it with the block.
module min_tracking_stack_checker
  import mts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     cmd,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] top_value,
  input  logic signed [DATA_W-1:0] min_value,
  input  logic [DEPTH_W-1:0]       depth,
  input  logic                     is_empty,
  input  logic [1:0]               status,
  output int                       fail_count,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] minimum;
    logic [DEPTH_W-1:0]       level;
    logic                     empty;
    logic [1:0]               code;
  } stack_view_t;

  logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] min_mem [STACK_DEPTH];
  int unsigned              value_cnt = 0;
  int unsigned              min_cnt = 0;
  stack_view_t              expected_views [$];
  int                       mismatches = 0;
  int                       waiting = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  // Apply one operation to the shadow stack and return the view the block should show.
  function automatic stack_view_t advance_stack(logic op, logic signed [DATA_W-1:0] v);
    stack_view_t view;
    view.code = ST_OK;
    if (op == CMD_PUSH) begin
      if (value_cnt >= STACK_DEPTH) begin
        view.code = ST_FULL;
      end else begin
        value_mem[value_cnt] = v;
        value_cnt++;
        if (min_cnt == 0 || v <= min_mem[min_cnt-1]) begin
          if (min_cnt < STACK_DEPTH) begin
            min_mem[min_cnt] = v;
            min_cnt++;
          end
        end
      end
    end else begin
      if (value_cnt == 0) begin
        view.code = ST_EMPTY;
      end else begin
        if (min_cnt > 0 && min_mem[min_cnt-1] == value_mem[value_cnt-1])
          min_cnt--;
        value_cnt--;
      end
    end
    view.top     = (value_cnt > 0) ? value_mem[value_cnt-1] : '0;
    view.minimum = (value_cnt > 0 && min_cnt > 0) ? min_mem[min_cnt-1] : '0;
    view.level   = DEPTH_W'(value_cnt);
    view.empty   = (value_cnt == 0);
    return view;
  endfunction

  task automatic report_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: MISMATCH on %s: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    stack_view_t want;
    if (rst) begin
      value_cnt = 0;
      min_cnt   = 0;
      expected_views.delete();
    end else begin
      // Compare the result first: it belongs to an earlier transfer.
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          mismatches++;
          $display("%0t ns: MISMATCH: result with nothing expected, top %0d min %0d depth %0d",
                   $time, top_value, min_value, depth);
        end else begin
          want = expected_views.pop_front();
          report_field("top_value", want.top, top_value);
          report_field("min_value", want.minimum, min_value);
          report_field("depth", want.level, depth);
          report_field("is_empty", want.empty, is_empty);
          report_field("status", want.code, status);
        end
      end
      if (in_valid && !in_stall)
        expected_views.push_back(advance_stack(cmd, push_value));
    end
    waiting <= expected_views.size();
  end

endmodule

// ===== tb/min_tracking_stack_test.sv =====
// Top of the minimum-tracking stack test: clock, reset, stimulus, output stalls and verdict.
module min_tracking_stack_test
  import mts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     cmd = CMD_PUSH;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;
  logic [DEPTH_W-1:0]       depth;
  logic                     is_empty;
  logic [1:0]               status;

  int          fail_count;
  int          outstanding;
  // Depth as the stimulus sees it, used only to steer towards full and empty.
  int unsigned fill_level = 0;
  // Set for the closing stretch: no gaps and no stalls from then on.
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  min_tracking_stack dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .top_value  (top_value),
    .min_value  (min_value),
    .depth      (depth),
    .is_empty   (is_empty),
    .status     (status)
  );

  min_tracking_stack_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_value   (top_value),
    .min_value   (min_value),
    .depth       (depth),
    .is_empty    (is_empty),
    .status      (status),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Stall the result channel in random bursts, with free stretches between.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!calm && !rst && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 10);
    end
  end

  // Watchdog: end the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Draw a value: often a narrow band around zero so that ties and new minima are common,
  // sometimes an extreme, otherwise any 32-bit word.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $signed($urandom_range(0, 16)) - 8;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one item, maybe after an idle gap, and hold it until the block takes it.
  task automatic transfer_op(logic op, logic signed [DATA_W-1:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    push_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == CMD_PUSH && fill_level < STACK_DEPTH)
      fill_level++;
    else if (op == CMD_POP && fill_level > 0)
      fill_level--;
    @(negedge clk);
  endtask

  // Random item with the given chance of a push, in percent; pops carry noise values.
  task automatic random_op(int push_pct);
    logic op;
    op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
    transfer_op(op, pick_value());
  endtask

  initial begin
    // Hold reset at the start, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pop when empty, the extremes, a tied minimum, then unwind to empty.
    transfer_op(CMD_POP,  32'sh5A5A_5A5A);
    transfer_op(CMD_PUSH, 32'sh7FFF_FFFF);
    transfer_op(CMD_PUSH, 32'sh8000_0000);
    transfer_op(CMD_PUSH, 32'sh8000_0000);
    transfer_op(CMD_PUSH, 32'sh0000_0000);
    transfer_op(CMD_POP,  32'shFFFF_FFFF);
    transfer_op(CMD_POP,  32'sh0000_0000);
    transfer_op(CMD_POP,  32'sh0000_0000);
    transfer_op(CMD_POP,  32'sh0000_0000);
    transfer_op(CMD_POP,  32'sh0000_0000);
    // Equal values, a new minimum, a larger value, a tied minimum and a lower one.
    transfer_op(CMD_PUSH, 32'sd7);
    transfer_op(CMD_PUSH, 32'sd7);
    transfer_op(CMD_PUSH, 32'sd3);
    transfer_op(CMD_PUSH, 32'sd9);
    transfer_op(CMD_PUSH, 32'sd3);
    transfer_op(CMD_PUSH, -32'sd1);
    repeat (7) transfer_op(CMD_POP, 32'sd0);

    // Mixed walk near the bottom: plenty of refused pops.
    repeat (150) random_op(50);

    // Fill to the top, then push against a full stack.
    while (fill_level < STACK_DEPTH) random_op(94);
    repeat (6) transfer_op(CMD_PUSH, pick_value());

    // Drain to empty; drop all idling for the closing stretch.
    while (fill_level > 0) begin
      if (fill_level < 200)
        calm = 1'b1;
      random_op(6);
    end
    repeat (4) transfer_op(CMD_POP, pick_value());
    in_valid <= 1'b0;

    // Wait for every expected result, then let the pipeline settle.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
